FILE: hw/rtl/pbf_pkg.sv
package pbf_pkg;

	// default bin lengths in bits, each a prime
	localparam int BIN_ONE_PRIME_DEF   = 5791;
	localparam int BIN_TWO_PRIME_DEF   = 5827;
	localparam int BIN_THREE_PRIME_DEF = 5939;
	localparam int BIN_FOUR_PRIME_DEF  = 5987;

	// bits per memory word
	localparam int WORD_BITS = 32;
	localparam int BIT_SEL_W = $clog2(WORD_BITS);

	// field widths
	localparam int VALUE_W = 32;

	// item kinds carried on tuser
	typedef enum logic {
		KIND_CLEAR = 1'b0,
		KIND_MARK  = 1'b1
	} pbf_kind_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_BACK,
		ST_INDEX,
		ST_TEST,
		ST_CLEAR
	} pbf_state_t;

	// per-bin control from the sequencer
	typedef struct packed {
		logic read;
		logic write;
		logic clear;
	} pbf_ctrl_t;

endpackage

FILE: hw/rtl/pbf_bin.sv
module pbf_bin
	import pbf_pkg::*;
#(
	parameter int PRIME = BIN_ONE_PRIME_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [VALUE_W-1:0] value,
	input  pbf_ctrl_t          ctrl,
	output logic               hit
);

	localparam int DEPTH   = PRIME / WORD_BITS + 1;
	localparam int AW      = $clog2(DEPTH);
	localparam int IW      = $clog2(PRIME);
	// floor(log2 PRIME); PRIME is no power of two, so the reciprocal fits 32 bits
	localparam int SHIFT   = $clog2(PRIME) - 1;
	localparam logic [VALUE_W-1:0] RECIP =
		VALUE_W'((64'd1 << (VALUE_W + SHIFT)) / PRIME);
	localparam logic [VALUE_W-1:0] PRIME_W = VALUE_W'(PRIME);

	logic [2*VALUE_W-1:0] prod;
	logic [VALUE_W-1:0]   quo_s1;
	logic [VALUE_W-1:0]   back_s2;
	logic [VALUE_W-1:0]   rem_raw;
	logic [VALUE_W-1:0]   rem;
	logic [IW-1:0]        idx;
	logic [AW-1:0]        raddr;

	logic [WORD_BITS-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0]     vld_q;

	logic [WORD_BITS-1:0] rdata_s3;
	logic                 word_vld_s3;
	logic [AW-1:0]        addr_s3;
	logic [BIT_SEL_W-1:0] bit_s3;
	logic [WORD_BITS-1:0] wdata;

	// quotient estimate by reciprocal, at most one below the true quotient
	assign prod = {{VALUE_W{1'b0}}, value} * {{VALUE_W{1'b0}}, RECIP};

	// reduction pipeline
	always_ff @(posedge clk) begin
		quo_s1  <= VALUE_W'(prod >> (VALUE_W + SHIFT));
		back_s2 <= VALUE_W'(quo_s1 * PRIME_W);
	end

	// remainder with one correction step
	always_comb begin
		rem_raw = value - back_s2;
		if (rem_raw >= PRIME_W) begin
			rem = rem_raw - PRIME_W;
		end else begin
			rem = rem_raw;
		end
		idx   = IW'(rem);
		raddr = AW'(idx >> BIT_SEL_W);
	end

	// word memory: registered read, write back of the marked word
	always_ff @(posedge clk) begin
		if (ctrl.read) begin
			rdata_s3    <= mem_q[raddr];
			word_vld_s3 <= vld_q[raddr];
			addr_s3     <= raddr;
			bit_s3      <= BIT_SEL_W'(idx);
		end
		if (ctrl.write) begin
			mem_q[addr_s3] <= wdata;
		end
	end

	// word valid bits, an invalid word reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ctrl.clear) begin
			vld_q <= '0;
		end else if (ctrl.write) begin
			vld_q[addr_s3] <= 1'b1;
		end
	end

	// test and merge
	assign hit   = word_vld_s3 & rdata_s3[bit_s3];
	assign wdata = (word_vld_s3 ? rdata_s3 : '0) | (WORD_BITS'(1) << bit_s3);

endmodule

FILE: hw/rtl/partitioned_bloom_filter_mark_top.sv
// channel   | dir | tvalid/tready   | tdata                   | tuser
// s_axis    | in  | s_axis_tvalid/r | [31:0] value            | [0] kind (0 clear, 1 mark)
// m_axis    | out | m_axis_tvalid/r | [0] is_new, [7:1] zero  | -
//
// a mark result is registered at the end of the sequencer steps: reciprocal multiply,
// back multiply, remainder and memory read, then test and write back in the four bins
// a clear result is registered from the clear step
// one item in flight; the next transfer is taken only after the result is registered
// reset and clear drop the per-word valid bits at once, no sweep of the memories
// a stalled output holds the finished item in its last step until the output frees
module partitioned_bloom_filter_mark_top
	import pbf_pkg::*;
#(
	parameter int BIN_ONE_PRIME   = BIN_ONE_PRIME_DEF,
	parameter int BIN_TWO_PRIME   = BIN_TWO_PRIME_DEF,
	parameter int BIN_THREE_PRIME = BIN_THREE_PRIME_DEF,
	parameter int BIN_FOUR_PRIME  = BIN_FOUR_PRIME_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] value
	input  logic        s_axis_tuser,   // [0] kind
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata    // [0] is_new, [7:1] zero
);

	pbf_state_t         state_q;
	pbf_state_t         state_nxt;
	pbf_ctrl_t          ctrl;
	logic [VALUE_W-1:0] value_q;
	logic [3:0]         hits;
	logic               all_hit;
	logic               out_free;
	logic               out_load;
	logic               out_new;
	logic               out_valid_q;
	logic               is_new_q;

	// one bin per prime
	pbf_bin #(.PRIME(BIN_ONE_PRIME)) u_bin_one (
		.clk(clk), .arst_n(arst_n), .value(value_q), .ctrl(ctrl), .hit(hits[0])
	);
	pbf_bin #(.PRIME(BIN_TWO_PRIME)) u_bin_two (
		.clk(clk), .arst_n(arst_n), .value(value_q), .ctrl(ctrl), .hit(hits[1])
	);
	pbf_bin #(.PRIME(BIN_THREE_PRIME)) u_bin_three (
		.clk(clk), .arst_n(arst_n), .value(value_q), .ctrl(ctrl), .hit(hits[2])
	);
	pbf_bin #(.PRIME(BIN_FOUR_PRIME)) u_bin_four (
		.clk(clk), .arst_n(arst_n), .value(value_q), .ctrl(ctrl), .hit(hits[3])
	);

	assign all_hit  = &hits;
	assign out_free = !out_valid_q || m_axis_tready;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state and step controls
	always_comb begin
		state_nxt     = state_q;
		ctrl          = '0;
		s_axis_tready = 1'b0;
		out_load      = 1'b0;
		out_new       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (s_axis_tuser == KIND_CLEAR) begin
						ctrl.clear = 1'b1;
						state_nxt  = ST_CLEAR;
					end else begin
						state_nxt  = ST_MUL;
					end
				end
			end
			ST_MUL: begin
				state_nxt = ST_BACK;
			end
			ST_BACK: begin
				state_nxt = ST_INDEX;
			end
			ST_INDEX: begin
				ctrl.read = 1'b1;
				state_nxt = ST_TEST;
			end
			ST_TEST: begin
				if (out_free) begin
					ctrl.write = !all_hit;
					out_load   = 1'b1;
					out_new    = !all_hit;
					state_nxt  = ST_IDLE;
				end
			end
			ST_CLEAR: begin
				if (out_free) begin
					out_load  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// key capture on input transfer
	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			value_q <= s_axis_tdata;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			is_new_q <= out_new;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, is_new_q};

endmodule

FILE: tb/sv/tb_partitioned_bloom_filter_mark_top.sv
module tb_partitioned_bloom_filter_mark_top
	import pbf_pkg::*;
;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned HOLD_AFTER  = 600;
	localparam int unsigned RANDOM_ITEMS = 1700;
	localparam int unsigned DRAIN_CYCLES = 20;

	// shadow of the four bins and the queue of expected is_new flags
	class mark_tracker;
		int unsigned prime [4];
		bit bin_bits [4][BIN_FOUR_PRIME_DEF];   // bin four is the longest
		bit is_new_pending [$];
		int unsigned errors;
		int unsigned clears_taken;
		int unsigned marks_new;
		int unsigned marks_present;
		int unsigned results_checked;

		function new();
			prime[0] = BIN_ONE_PRIME_DEF;
			prime[1] = BIN_TWO_PRIME_DEF;
			prime[2] = BIN_THREE_PRIME_DEF;
			prime[3] = BIN_FOUR_PRIME_DEF;
			bin_bits = '{default: 1'b0};
		endfunction

		// update the shadow bins for one accepted item and queue its answer
		function void note_transfer(pbf_kind_t kind, logic [31:0] value);
			int unsigned idx [4];
			bit all_set;
			if (kind == KIND_CLEAR) begin
				bin_bits = '{default: 1'b0};
				is_new_pending.push_back(1'b0);
				clears_taken++;
				return;
			end
			all_set = 1'b1;
			for (int b = 0; b < 4; b++) begin
				idx[b] = value % prime[b];
				if (!bin_bits[b][idx[b]])
					all_set = 1'b0;
			end
			if (all_set) begin
				is_new_pending.push_back(1'b0);
				marks_present++;
			end else begin
				for (int b = 0; b < 4; b++)
					bin_bits[b][idx[b]] = 1'b1;
				is_new_pending.push_back(1'b1);
				marks_new++;
			end
		endfunction

		task report_mismatch(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		// compare one output transfer with the oldest expectation
		task check_result(logic [7:0] tdata);
			bit want;
			if (is_new_pending.size() == 0) begin
				report_mismatch($sformatf("unexpected result tdata=%h", tdata));
				return;
			end
			want = is_new_pending.pop_front();
			results_checked++;
			if (tdata[0] !== want)
				report_mismatch($sformatf("result %0d is_new=%b, want %b",
					results_checked, tdata[0], want));
			if (tdata[7:1] !== 7'd0)
				report_mismatch($sformatf("result %0d padding=%h, want zero",
					results_checked, tdata[7:1]));
		endtask

		function int unsigned pending();
			return is_new_pending.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;

	mark_tracker tracker;
	int unsigned sent_count = 0;
	int unsigned cycle_count = 0;
	logic [31:0] key_pool [$];

	partitioned_bloom_filter_mark_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles", cycle_count);
		$display("partitioned_bloom_filter_mark_top verification failed");
		$finish;
	end

	// output monitor
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			tracker.check_result(m_axis_tdata);
	end

	// receiver: phases of always ready, a fixed duty pattern and sparse ready,
	// plus one long hold-off once the run is under way
	initial begin
		int unsigned phase_left;
		int unsigned phase_kind;
		bit hold_done;
		phase_left = 0;
		phase_kind = 0;
		hold_done = 1'b0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && sent_count >= HOLD_AFTER) begin
				hold_done = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (phase_left == 0) begin
					phase_kind = $urandom_range(0, 2);
					phase_left = $urandom_range(10, 150);
				end
				phase_left--;
				case (phase_kind)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= (phase_left % 3 != 0);
					default: m_axis_tready <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	// offer one item and hold it until the transfer
	task automatic send_item(pbf_kind_t kind, logic [31:0] value);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= value;
		do
			@(posedge clk);
		while (!s_axis_tready);
		tracker.note_transfer(kind, value);
		sent_count++;
		if (kind == KIND_MARK) begin
			key_pool.push_back(value);
			if (key_pool.size() > 64)
				void'(key_pool.pop_front());
		end
	endtask

	// drop valid for a while with junk on the data lines
	task automatic idle_gap(int unsigned cycles);
		if (cycles == 0)
			return;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= $urandom;
		s_axis_tuser  <= 1'($urandom_range(0, 1));
		repeat (cycles) @(posedge clk);
	endtask

	// pick a key: repeats, near aliases of earlier keys, a dense low range or anything
	function automatic logic [31:0] pick_key();
		int unsigned r;
		logic [31:0] base;
		r = $urandom_range(0, 99);
		if (key_pool.size() == 0 || r >= 80)
			return $urandom;
		base = key_pool[$urandom_range(0, key_pool.size() - 1)];
		if (r < 35)
			return base;
		if (r < 55)
			return base + $urandom_range(1, 3) * tracker.prime[$urandom_range(0, 3)];
		return $urandom_range(0, 20000);
	endfunction

	initial begin
		int unsigned burst_left;
		int unsigned gap;
		tracker = new();
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 32'd0;
		s_axis_tuser  <= KIND_CLEAR;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: clear, repeats, extremes, last index of bins one and four
		send_item(KIND_CLEAR, 32'hFFFF_FFFF);
		send_item(KIND_MARK, 32'd0);
		send_item(KIND_MARK, 32'd0);
		idle_gap(3);
		send_item(KIND_MARK, 32'hFFFF_FFFF);
		send_item(KIND_MARK, 32'hFFFF_FFFF);
		send_item(KIND_MARK, BIN_ONE_PRIME_DEF);   // aliases zero in bin one only
		send_item(KIND_MARK, BIN_ONE_PRIME_DEF - 1);
		send_item(KIND_MARK, BIN_FOUR_PRIME_DEF - 1);
		send_item(KIND_MARK, 32'h8000_0000);
		idle_gap(1);
		// set key 100's bit in each bin through other keys: false positive
		send_item(KIND_MARK, 100 + BIN_ONE_PRIME_DEF);
		send_item(KIND_MARK, 100 + BIN_TWO_PRIME_DEF);
		send_item(KIND_MARK, 100 + BIN_THREE_PRIME_DEF);
		send_item(KIND_MARK, 100 + BIN_FOUR_PRIME_DEF);
		send_item(KIND_MARK, 32'd100);
		// clear then the same keys are new again
		send_item(KIND_CLEAR, 32'd0);
		send_item(KIND_MARK, 32'd100);
		send_item(KIND_MARK, 32'd0);
		send_item(KIND_MARK, 32'hAAAA_AAAA);
		send_item(KIND_MARK, 32'h5555_5555);
		send_item(KIND_CLEAR, 32'h1234_5678);
		send_item(KIND_CLEAR, 32'd0);
		send_item(KIND_MARK, 32'd0);
		idle_gap(2);

		// random bursts
		burst_left = 0;
		gap = 0;
		for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			end
			if ($urandom_range(0, 99) < 3)
				send_item(KIND_CLEAR, $urandom);
			else
				send_item(KIND_MARK, pick_key());
			burst_left--;
			if (burst_left == 0)
				idle_gap(gap);
		end
		s_axis_tvalid <= 1'b0;

		// drain
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items: %0d new marks, %0d marks already present, %0d clears",
			sent_count, tracker.marks_new, tracker.marks_present, tracker.clears_taken);
		$display("%0d results checked, %0d mismatches, one %0d-cycle output hold-off",
			tracker.results_checked, tracker.errors, LONG_HOLD);
		if (tracker.errors == 0)
			$display("partitioned_bloom_filter_mark_top verification clean");
		else
			$display("partitioned_bloom_filter_mark_top verification failed");
		$finish;
	end

endmodule
